### hdl/b58d_pkg.sv
// Shared types, constants and alphabet lookup for the Base58 decoder.
package b58d_pkg;

  // Accumulator geometry: bytes are held in rows of eight
  localparam int MAX_BYTES = 64;
  localparam int ROW_BYTES = 8;
  localparam int ROW_BITS  = ROW_BYTES * 8;
  localparam int NUM_ROWS  = MAX_BYTES / ROW_BYTES;
  localparam int IDX_W     = $clog2(MAX_BYTES);
  localparam int ROW_W     = $clog2(NUM_ROWS);
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int POS_W     = $clog2(ROW_BYTES + 1);

  // Digit arithmetic
  localparam int RADIX     = 58;
  localparam int DIGIT_W   = 6;
  localparam int CARRY_W   = 6;
  localparam int MAC_W     = 14;
  localparam int NUM_SYMS  = 58;

  // Symbol k sits at bits [8*(NUM_SYMS-1-k) +: 8]
  localparam logic [8*NUM_SYMS-1:0] ALPHA_STD =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
  localparam logic [8*NUM_SYMS-1:0] ALPHA_ALT =
    "rpshnaf39wBUDNEGHJKLM4PQRST7VWXYZ2bcdeCg65jkm8oFqi1tuvAxyz";

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_ZERO,
    PH_DIGIT,
    PH_TRAIL
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_INVALID,
    ST_EXTRA,
    ST_OVERFLOW
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FOLD_RD,
    S_FOLD,
    S_END,
    S_TRIM_RD,
    S_TRIM_CHK,
    S_DECIDE,
    S_ZEROS,
    S_ROW_RD,
    S_BYTES,
    S_SINGLE
  } fsm_e;

  typedef struct packed {
    logic               hit;
    logic [DIGIT_W-1:0] value;
  } digit_t;

  // Result of folding one accumulator row
  typedef struct packed {
    logic [ROW_BITS-1:0] data;
    logic [CARRY_W-1:0]  carry;
    logic [POS_W-1:0]    hi_pos;   // bytes of the row reached by a carry
  } fold_res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic digit_t digit_lookup(input logic sel, input logic [7:0] c);
    digit_t                  res;
    logic [8*NUM_SYMS-1:0]   tab;
    res = '0;
    tab = sel ? ALPHA_ALT : ALPHA_STD;
    for (int k = 0; k < NUM_SYMS; k++) begin
      if (tab[8*(NUM_SYMS-1-k) +: 8] == c) begin
        res.hit   = 1'b1;
        res.value = DIGIT_W'(k);
      end
    end
    return res;
  endfunction

endpackage

### hdl/b58d_fold_row.sv
// Shared multiply-accumulate unit: one accumulator row times 58 plus carry.
module b58d_fold_row import b58d_pkg::*; (
  input  logic [ROW_BITS-1:0]  row_i,
  input  logic [ROW_BYTES-1:0] live_i,
  input  logic [CARRY_W-1:0]   carry_i,
  output fold_res_t            res_o
);

  logic [CARRY_W-1:0] carry [ROW_BYTES+1];
  logic [MAC_W-1:0]   prod  [ROW_BYTES];
  logic [7:0]         byte_in [ROW_BYTES];

  // Byte chain, least significant first; bytes past the used length read as zero
  always_comb begin
    carry[0] = carry_i;
    for (int j = 0; j < ROW_BYTES; j++) begin
      byte_in[j]   = live_i[j] ? row_i[8*j +: 8] : 8'd0;
      prod[j]      = MAC_W'(byte_in[j]) * MAC_W'(RADIX) + MAC_W'(carry[j]);
      carry[j+1]   = prod[j][MAC_W-1:8];
    end
  end

  // Pack the result and find how far the carry reached in this row
  always_comb begin
    res_o.carry  = carry[ROW_BYTES];
    res_o.hi_pos = '0;
    for (int j = 0; j < ROW_BYTES; j++) begin
      res_o.data[8*j +: 8] = prod[j][7:0];
      if (carry[j] != '0) begin
        res_o.hi_pos = POS_W'(j + 1);
      end
    end
  end

endmodule

### hdl/base58_decoder.sv
// Top level of the streaming Base58 decoder.
// Base58 decoder taking one character per item and returning the decoded
// bytes, most significant first, once the item flagged last_char_i arrives.
// The input is ready only in the idle state. A whitespace, zero-digit or
// error-ignored character that is not the last leaves the block idle. A
// significant digit is folded into the 64-byte accumulator (eight rows of
// eight bytes in a local memory) by one shared row multiply-accumulate unit:
// the digit is accepted, a memory read follows, then one row is folded per
// step for each row the carry or the used length touch (1 to 8). At the end
// of a string the path is picked, then the top row holding a nonzero byte is
// found by scanning rows downward, each with a read and a check step, then
// the length is checked; zero bytes then leave at one per cycle and
// significant bytes at one per cycle, with a memory read ahead of each row,
// while the output is not stalled. An error or an empty string gives one item.
// The accumulator is never swept: bytes beyond the used length read as zero.
module base58_decoder import b58d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_byte_o,
  output logic       last_byte_o,
  output logic [1:0] status_o,
  output logic       empty_result_o
);

  fsm_e                state_q, state_d;
  phase_e              phase_q, phase_d;
  status_e             err_q, err_d;
  logic [CNT_W-1:0]    zc_q, zc_d;
  logic [CNT_W-1:0]    used_q, used_d;
  logic [CNT_W-1:0]    n_q, n_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [CARRY_W-1:0]  carry_q, carry_d;
  logic                last_q, last_d;
  logic                alpha_q;

  logic                out_valid_q;
  logic [7:0]          out_byte_q;
  logic                out_last_q;
  status_e             out_status_q;
  logic                out_empty_q;

  logic                in_acc;
  logic                out_free;
  logic                sp;
  digit_t              dig;
  logic                do_fold;
  logic                fold_cont;
  logic                fold_ovf;
  logic                trim_hit;
  logic [CNT_W-1:0]    trim_n;
  logic [CNT_W:0]      total;
  logic [IDX_W-1:0]    emit_idx;
  logic [CNT_W-1:0]    next_base;
  logic [CNT_W-1:0]    cand;

  // Memory port controls and output load
  logic                mem_re, mem_we;
  logic [ROW_W-1:0]    mem_raddr;
  logic [ROW_BITS-1:0] rd_q;
  logic [ROW_BYTES-1:0] live;
  fold_res_t           fold;
  logic                out_load;
  logic [7:0]          load_byte;
  logic                load_last;
  status_e             load_status;
  logic                load_empty;

  logic [ROW_BITS-1:0] acc_mem [NUM_ROWS];

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign sp       = is_space(char_code_i);
  assign dig      = digit_lookup(alpha_q, char_code_i);
  assign total    = (CNT_W+1)'(zc_q) + (CNT_W+1)'(n_q);
  assign emit_idx = IDX_W'(n_q - CNT_W'(1));

  // Bytes of the current row that lie below the used length
  always_comb begin
    for (int j = 0; j < ROW_BYTES; j++) begin
      live[j] = (CNT_W'({row_q, 3'(j)}) < used_q);
    end
  end

  b58d_fold_row u_fold (
    .row_i   (rd_q),
    .live_i  (live),
    .carry_i (carry_q),
    .res_o   (fold)
  );

  // Fold control: carry out of the row and the old used length decide
  assign next_base = CNT_W'({row_q, 3'b000}) + CNT_W'(ROW_BYTES);
  assign cand      = CNT_W'({row_q, 3'b000}) + CNT_W'(fold.hi_pos);
  assign fold_cont = ((fold.carry != '0) || (next_base < used_q)) &&
                     (row_q != ROW_W'(NUM_ROWS - 1));
  assign fold_ovf  = (fold.carry != '0) && (row_q == ROW_W'(NUM_ROWS - 1));

  // Highest nonzero live byte of the row under scan
  always_comb begin
    trim_hit = 1'b0;
    trim_n   = '0;
    for (int j = 0; j < ROW_BYTES; j++) begin
      if (live[j] && (rd_q[8*j +: 8] != 8'd0)) begin
        trim_hit = 1'b1;
        trim_n   = CNT_W'({row_q, 3'(j)}) + CNT_W'(1);
      end
    end
  end

  // Character classification for the accepted item
  always_comb begin
    phase_d = phase_q;
    err_d   = err_q;
    zc_d    = zc_q;
    do_fold = 1'b0;
    if (in_acc && (err_q == ST_OK)) begin
      if (phase_q == PH_TRAIL) begin
        if (!sp) err_d = ST_EXTRA;
      end else if (sp) begin
        if (phase_q != PH_LEAD) phase_d = PH_TRAIL;
      end else if (!dig.hit) begin
        err_d = ST_INVALID;
      end else if ((phase_q != PH_DIGIT) && (dig.value == '0)) begin
        phase_d = PH_ZERO;
        if (zc_q >= CNT_W'(MAX_BYTES)) begin
          err_d = ST_OVERFLOW;
        end else begin
          zc_d = zc_q + CNT_W'(1);
        end
      end else begin
        phase_d = PH_DIGIT;
        do_fold = 1'b1;
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (do_fold)          state_d = S_FOLD_RD;
          else if (last_char_i) state_d = S_END;
        end
      end
      S_FOLD_RD: state_d = S_FOLD;
      S_FOLD: begin
        if (!fold_cont) state_d = last_q ? S_END : S_IDLE;
      end
      S_END: begin
        if (err_q != ST_OK)      state_d = S_SINGLE;
        else if (used_q == '0)   state_d = S_DECIDE;
        else                     state_d = S_TRIM_RD;
      end
      S_TRIM_RD: state_d = S_TRIM_CHK;
      S_TRIM_CHK: begin
        if (trim_hit || (row_q == '0)) state_d = S_DECIDE;
        else                           state_d = S_TRIM_RD;
      end
      S_DECIDE: begin
        if ((total > (CNT_W+1)'(MAX_BYTES)) || (total == '0)) state_d = S_SINGLE;
        else if (zc_q != '0)                                 state_d = S_ZEROS;
        else                                                 state_d = S_ROW_RD;
      end
      S_ZEROS: begin
        if (out_free && (zc_q == CNT_W'(1))) begin
          state_d = (n_q == '0) ? S_IDLE : S_ROW_RD;
        end
      end
      S_ROW_RD: state_d = S_BYTES;
      S_BYTES: begin
        if (out_free) begin
          if (n_q == CNT_W'(1))          state_d = S_IDLE;
          else if (emit_idx[2:0] == '0)  state_d = S_ROW_RD;
        end
      end
      S_SINGLE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Memory port and output register controls
  always_comb begin
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_raddr   = row_q;
    out_load    = 1'b0;
    load_byte   = 8'd0;
    load_last   = 1'b0;
    load_status = ST_OK;
    load_empty  = 1'b0;
    unique case (state_q)
      S_FOLD_RD, S_TRIM_RD: begin
        mem_re = 1'b1;
      end
      S_FOLD: begin
        mem_we    = 1'b1;
        mem_re    = fold_cont;
        mem_raddr = row_q + ROW_W'(1);
      end
      S_ROW_RD: begin
        mem_re    = 1'b1;
        mem_raddr = emit_idx[IDX_W-1:3];
      end
      S_ZEROS: begin
        out_load  = out_free;
        load_last = (zc_q == CNT_W'(1)) && (n_q == '0);
      end
      S_BYTES: begin
        out_load  = out_free;
        load_byte = rd_q[8*emit_idx[2:0] +: 8];
        load_last = (n_q == CNT_W'(1));
      end
      S_SINGLE: begin
        out_load    = out_free;
        load_last   = 1'b1;
        load_status = err_q;
        load_empty  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Working register next values
  always_comb begin
    used_d  = used_q;
    n_d     = n_q;
    row_d   = row_q;
    carry_d = carry_q;
    last_d  = last_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          last_d  = last_char_i;
          row_d   = '0;
          carry_d = CARRY_W'(dig.value);
        end
      end
      S_FOLD: begin
        carry_d = fold.carry;
        if ((fold.hi_pos != '0) && (cand > used_q)) used_d = cand;
        if (fold_cont) row_d = row_q + ROW_W'(1);
      end
      S_END: begin
        n_d   = '0;
        row_d = ROW_W'((used_q - CNT_W'(1)) >> 3);
      end
      S_TRIM_CHK: begin
        if (trim_hit)            n_d   = trim_n;
        else if (row_q != '0)    row_d = row_q - ROW_W'(1);
      end
      S_BYTES: begin
        if (out_free) n_d = n_q - CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_LEAD;
      err_q   <= ST_OK;
      zc_q    <= '0;
      used_q  <= '0;
      n_q     <= '0;
      row_q   <= '0;
      carry_q <= '0;
      last_q  <= 1'b0;
      alpha_q <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      row_q   <= row_d;
      carry_q <= carry_d;
      last_q  <= last_d;
      if (cfg_we_i) alpha_q <= cfg_data_i;
      if ((state_q != S_IDLE) && (state_d == S_IDLE) && (state_q != S_FOLD || last_q)) begin
        // string finished: clear for the next one
        phase_q <= PH_LEAD;
        err_q   <= ST_OK;
        zc_q    <= '0;
        used_q  <= '0;
      end else if (state_q == S_IDLE) begin
        phase_q <= phase_d;
        err_q   <= err_d;
        zc_q    <= zc_d;
      end else begin
        used_q <= used_d;
        if (state_q == S_FOLD && fold_ovf) err_q <= ST_OVERFLOW;
        if (state_q == S_DECIDE && total > (CNT_W+1)'(MAX_BYTES)) err_q <= ST_OVERFLOW;
        if (state_q == S_ZEROS && out_free) zc_q <= zc_q - CNT_W'(1);
      end
    end
  end

  // Accumulator rows
  always_ff @(posedge clk_i) begin
    if (mem_we) acc_mem[row_q] <= fold.data;
    if (mem_re) rd_q <= acc_mem[mem_raddr];
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_byte_q   <= load_byte;
      out_last_q   <= load_last;
      out_status_q <= load_status;
      out_empty_q  <= load_empty;
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign data_byte_o    = out_byte_q;
  assign last_byte_o    = out_last_q;
  assign status_o       = out_status_q;
  assign empty_result_o = out_empty_q;

endmodule

### hdl/b58d_checker.sv
// Port-level checker for the Base58 decoder, bound to the top level.
module b58d_checker import b58d_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       last_char_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] data_byte_o,
  input logic       last_byte_o,
  input logic [1:0] status_o,
  input logic       empty_result_o
);

  // A stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(data_byte_o) &&
    $stable(last_byte_o) && $stable(status_o) && $stable(empty_result_o))
    else $error("output item changed while stalled");

  // An empty result closes its string and carries a zero byte
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_result_o |-> last_byte_o && (data_byte_o == 8'd0))
    else $error("empty result not final or not zero");

  // Errors come only as empty results
  a_err_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> empty_result_o)
    else $error("error status on a data item");

  // The last character always starts the end-of-string work
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_char_i |=> in_stall_o)
    else $error("input ready right after the last character");

endmodule

bind base58_decoder b58d_checker u_b58d_checker (.*);

### tb/sv/testbench.sv
// Self-checking testbench for the streaming Base58 decoder.
module testbench;
  import b58d_pkg::*;

  localparam int BASE          = 58;
  localparam int SETTLE_CYCLES = 40;         // longest fold plus end-of-string scan, with margin
  localparam int RAND_PER_PHASE = 14;
  localparam int NUM_PHASES    = 6;

  typedef struct {
    logic [7:0] code;
    logic       is_last;
  } char_item_t;

  typedef struct {
    logic [7:0] byte_val;
    logic       is_last;
    status_e    status;
    logic       is_empty;
  } byte_res_t;

  typedef enum {
    STR_PLAIN,
    STR_INVALID,
    STR_EXTRA,
    STR_NOISE,
    STR_ACC_OVF,
    STR_LONG_OUT,
    STR_FULL,
    STR_MANY_ZEROS
  } str_kind_e;

  // Block ports
  logic       clk_i;
  logic       rst_ni         = 1'b0;
  logic       cfg_we_i       = 1'b0;
  logic       cfg_data_i     = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_stall_o;
  logic [7:0] char_code_i    = 8'h00;
  logic       last_char_i    = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i    = 1'b0;
  logic [7:0] data_byte_o;
  logic       last_byte_o;
  logic [1:0] status_o;
  logic       empty_result_o;

  string alphabet [2] = '{
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz",
    "rpshnaf39wBUDNEGHJKLM4PQRST7VWXYZ2bcdeCg65jkm8oFqi1tuvAxyz"
  };

  // Stimulus and expected results
  char_item_t char_q [$];
  byte_res_t  decoded_q [$];
  char_item_t next_char;
  byte_res_t  want;

  // Decoder shadow state
  logic [7:0] acc_q [MAX_BYTES];
  phase_e     ph_q;
  int         zeros_q;
  int         used_q;
  status_e    err_q;
  logic       alpha_q;

  // Handshake pacing
  logic in_taken = 1'b0;
  logic quiet    = 1'b0;
  int   gap_left;
  int   burst_left;
  int   stall_left;
  int   run_left;

  // Bookkeeping
  int fails;
  int chars_taken;
  int strings_taken;
  int results_checked;
  int queued_in_phase;
  int kind_seen [4];

  base58_decoder uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .last_char_i    (last_char_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .data_byte_o    (data_byte_o),
    .last_byte_o    (last_byte_o),
    .status_o       (status_o),
    .empty_result_o (empty_result_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // Digit value of c in the chosen alphabet, -1 when it is not a symbol
  function automatic int sym_value(input logic sel, input logic [7:0] c);
    for (int k = 0; k < BASE; k++)
      if (alphabet[sel].getc(k) == c) return k;
    return -1;
  endfunction

  function automatic logic [7:0] pick_sym(input logic sel, input int lo);
    return 8'(alphabet[sel].getc($urandom_range(lo, BASE - 1)));
  endfunction

  function automatic logic [7:0] pick_blank();
    int r;
    r = $urandom_range(8, 13);
    return (r == 8) ? 8'd32 : 8'(r);
  endfunction

  function automatic logic [7:0] pick_invalid(input logic sel);
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (is_blank(c) || sym_value(sel, c) >= 0) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic str_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return STR_PLAIN;
    if (r < 70) return STR_INVALID;
    if (r < 83) return STR_EXTRA;
    if (r < 96) return STR_NOISE;
    if (r == 96) return STR_ACC_OVF;
    if (r == 97) return STR_LONG_OUT;
    if (r == 98) return STR_FULL;
    return STR_MANY_ZEROS;
  endfunction

  // Works out the bytes a string yields, one character at a time
  task automatic decode_char(input logic [7:0] c, input logic last);
    int        d;
    int        carry;
    int        i;
    int        n;
    int        total;
    byte_res_t r;
    if (err_q == ST_OK) begin
      if (ph_q == PH_TRAIL) begin
        if (!is_blank(c)) err_q = ST_EXTRA;
      end else if (is_blank(c)) begin
        if (ph_q != PH_LEAD) ph_q = PH_TRAIL;
      end else begin
        d = sym_value(alpha_q, c);
        if (d < 0) begin
          err_q = ST_INVALID;
        end else if (ph_q != PH_DIGIT && d == 0) begin
          ph_q = PH_ZERO;
          if (zeros_q >= MAX_BYTES) err_q = ST_OVERFLOW;
          else zeros_q++;
        end else begin
          // acc = acc * 58 + digit, little-endian bytes
          ph_q  = PH_DIGIT;
          carry = d;
          i     = 0;
          while ((carry != 0 || i < used_q) && i < MAX_BYTES) begin
            carry    = carry + BASE * acc_q[i];
            acc_q[i] = carry[7:0];
            carry    = carry >> 8;
            i++;
          end
          if (carry != 0) err_q = ST_OVERFLOW;
          else used_q = i;
        end
      end
    end
    if (last) begin
      n = used_q;
      while (n > 0 && acc_q[n - 1] == 8'h00) n--;
      total = zeros_q + n;
      if (err_q == ST_OK && total > MAX_BYTES) err_q = ST_OVERFLOW;
      if (err_q != ST_OK || total == 0) begin
        r = '{byte_val: 8'h00, is_last: 1'b1, status: err_q, is_empty: 1'b1};
        decoded_q.push_back(r);
      end else begin
        for (i = 0; i < total; i++) begin
          r.byte_val = (i < zeros_q) ? 8'h00 : acc_q[total - 1 - i];
          r.is_last  = (i == total - 1);
          r.status   = ST_OK;
          r.is_empty = 1'b0;
          decoded_q.push_back(r);
        end
      end
      foreach (acc_q[j]) acc_q[j] = 8'h00;
      ph_q    = PH_LEAD;
      zeros_q = 0;
      used_q  = 0;
      err_q   = ST_OK;
    end
  endtask

  task automatic push_char(input logic [7:0] c, input logic last);
    char_item_t it;
    it.code    = c;
    it.is_last = last;
    char_q.push_back(it);
    queued_in_phase++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(8'(s.getc(i)), i == s.len() - 1);
  endtask

  // Builds one string of the given shape with random content
  task automatic gen_string(input logic sel, input str_kind_e kind);
    logic [7:0] text [$];
    logic [7:0] g;
    case (kind)
      STR_PLAIN, STR_INVALID: begin
        repeat ($urandom_range(0, 2)) text.push_back(pick_blank());
        repeat ($urandom_range(0, 3)) text.push_back(8'(alphabet[sel].getc(0)));
        repeat ($urandom_range(0, 12)) text.push_back(pick_sym(sel, 0));
        repeat ($urandom_range(0, 2)) text.push_back(pick_blank());
        if (text.size() == 0) text.push_back(pick_blank());
        if (kind == STR_INVALID) text[$urandom_range(0, text.size() - 1)] = pick_invalid(sel);
      end
      STR_EXTRA: begin
        repeat ($urandom_range(1, 6)) text.push_back(pick_sym(sel, 0));
        text.push_back(pick_blank());
        g = 8'($urandom_range(0, 255));
        while (is_blank(g)) g = 8'($urandom_range(0, 255));
        text.push_back(g);
        repeat ($urandom_range(0, 2)) text.push_back(8'($urandom_range(0, 255)));
      end
      STR_NOISE: begin
        repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
      end
      STR_ACC_OVF: begin
        // 89 or more digits always carry out of the top byte
        text.push_back(pick_sym(sel, 1));
        repeat ($urandom_range(88, 90)) text.push_back(pick_sym(sel, 0));
      end
      STR_LONG_OUT: begin
        // 87 digits fill 63 or 64 bytes, two or three leading zeros push it past the limit
        repeat ($urandom_range(2, 3)) text.push_back(8'(alphabet[sel].getc(0)));
        text.push_back(pick_sym(sel, 1));
        repeat (86) text.push_back(pick_sym(sel, 0));
      end
      STR_FULL: begin
        text.push_back(pick_sym(sel, 1));
        repeat (86) text.push_back(pick_sym(sel, 0));
        if ($urandom_range(0, 1)) text.push_back(pick_blank());
      end
      default: begin
        repeat ($urandom_range(63, 65)) text.push_back(8'(alphabet[sel].getc(0)));
        if ($urandom_range(0, 1)) text.push_back(pick_blank());
      end
    endcase
    foreach (text[i]) push_char(text[i], i == text.size() - 1);
  endtask

  task automatic write_alphabet(input logic sel);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= sel;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    alpha_q = sel;
  endtask

  // Hold the sender back until every expected byte is out and the block has settled
  task automatic drain();
    while (char_q.size() != 0 || in_valid_i || decoded_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Sender: bursts of items separated by random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (gap_left > 0 && !quiet) begin
        in_valid_i <= 1'b0;
        gap_left--;
      end else if (char_q.size() > 0) begin
        next_char = char_q.pop_front();
        char_code_i <= next_char.code;
        last_char_i <= next_char.is_last;
        in_valid_i  <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 3);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: free runs interleaved with short and occasional long stalls
  always @(negedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (run_left > 0) begin
      out_stall_i <= 1'b0;
      run_left--;
    end else begin
      run_left    = $urandom_range(0, 12);
      stall_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 3);
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: check results against the shadow decoder, predict on each accepted item
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result: data_byte %0h status %0d", data_byte_o, status_o);
          fails++;
        end else begin
          want = decoded_q.pop_front();
          results_checked++;
          // data_byte carries nothing on an empty result
          if (!want.is_empty && data_byte_o !== want.byte_val) begin
            $error("data_byte: expected %0h, got %0h", want.byte_val, data_byte_o);
            fails++;
          end
          if (last_byte_o !== want.is_last) begin
            $error("last_byte: expected %0b, got %0b", want.is_last, last_byte_o);
            fails++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            fails++;
          end
          if (empty_result_o !== want.is_empty) begin
            $error("empty_result: expected %0b, got %0b", want.is_empty, empty_result_o);
            fails++;
          end
          if (want.is_empty) kind_seen[want.status]++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        chars_taken++;
        if (last_char_i) strings_taken++;
        decode_char(char_code_i, last_char_i);
      end
    end
  end

  // Main sequence
  initial begin
    logic sel;
    foreach (acc_q[j]) acc_q[j] = 8'h00;
    ph_q    = PH_LEAD;
    zeros_q = 0;
    used_q  = 0;
    err_q   = ST_OK;
    alpha_q = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed strings, first alphabet
    write_alphabet(1'b0);
    push_text(" ");                       // whitespace only: empty result
    push_text("1");                       // single zero digit
    push_text("z");                       // top digit
    push_char(8'h00, 1'b1);               // lowest code: invalid
    push_char(8'hff, 1'b1);               // highest code: invalid
    push_char(8'd9, 1'b0);                // tab lead, digit, trailing space, CR last
    push_char("2", 1'b0);
    push_char(8'd32, 1'b0);
    push_char(8'd13, 1'b1);
    push_text("2 3");                     // garbage after trailing space
    push_char("1", 1'b0);                 // invalid code in trailing space is garbage
    push_char(8'd32, 1'b0);
    push_char(8'h80, 1'b1);
    push_text("0 x");                     // first error wins
    push_text("11z");                     // zero bytes ahead of the value
    push_char("2", 1'b0);                 // string continues after the alphabet switch
    drain();
    write_alphabet(1'b1);
    push_char("p", 1'b1);
    drain();

    // Random phases, alternating alphabet, one phase without idling
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      sel = (ph % 2 == 0);
      write_alphabet(sel);
      quiet = (ph == 4);
      case (ph)
        0: gen_string(sel, STR_ACC_OVF);
        1: gen_string(sel, STR_LONG_OUT);
        2: gen_string(sel, STR_MANY_ZEROS);
        3: gen_string(sel, STR_FULL);
        default: ;
      endcase
      queued_in_phase = 0;
      while (queued_in_phase < RAND_PER_PHASE) gen_string(sel, pick_kind());
      drain();
    end
    quiet = 1'b0;

    $display("covered %0d strings, %0d characters, both alphabets; %0d results checked",
             strings_taken, chars_taken, results_checked);
    $display("single-item results: empty %0d, invalid %0d, extra %0d, overflow %0d",
             kind_seen[ST_OK], kind_seen[ST_INVALID], kind_seen[ST_EXTRA],
             kind_seen[ST_OVERFLOW]);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule

### sim.f
hdl/b58d_pkg.sv
hdl/b58d_fold_row.sv
hdl/base58_decoder.sv
hdl/b58d_checker.sv
tb/sv/testbench.sv
